// File: rtl/core/footswitch_gesture_decoder_defines.svh
// Assertion macros shared by the gesture decoder modules.
`ifndef FOOTSWITCH_GESTURE_DECODER_DEFINES_SVH
`define FOOTSWITCH_GESTURE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FGD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gesture decoder check failed");

// Next-cycle implication, disabled while reset is high.
`define FGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gesture decoder check failed");

`endif

// File: rtl/core/fgd_pkg.sv
// Shared types, constants and helpers of the footswitch gesture decoder.
package fgd_pkg;

   localparam int AGE_BITS   = 12;
   localparam int CFG_W      = 12;
   localparam int CMP_W      = (AGE_BITS > CFG_W) ? AGE_BITS : CFG_W;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int EV_N       = 9;

   localparam logic [CFG_W-1:0] COMBO_RESET = CFG_W'(45);
   localparam logic [CFG_W-1:0] TUNER_RESET = CFG_W'(2000);
   localparam logic [CFG_W-1:0] QUIT_RESET  = CFG_W'(2000);

   // Register indexes of the config port.
   localparam logic [1:0] CSR_COMBO = 2'd0;
   localparam logic [1:0] CSR_TUNER = 2'd1;
   localparam logic [1:0] CSR_QUIT  = 2'd2;

   localparam logic signed [1:0] RIG_PREV = 2'sb11;
   localparam logic signed [1:0] RIG_NEXT = 2'sb01;
   localparam logic signed [1:0] RIG_NONE = 2'sb00;

   typedef logic [AGE_BITS-1:0] age_type;
   typedef logic [CFG_W-1:0]    cfg_type;

   typedef enum logic [2:0] {
      KIND_TAP    = 3'd0,
      KIND_RIG    = 3'd1,
      KIND_TUNER  = 3'd2,
      KIND_SELECT = 3'd3,
      KIND_QUIT   = 3'd4
   } kind_type;

   // Bit positions of a tick record, in delivery order.
   typedef enum logic [3:0] {
      EV_RIG_PREV = 4'd0,
      EV_RIG_NEXT = 4'd1,
      EV_TAP0     = 4'd2,
      EV_TAP1     = 4'd3,
      EV_TAP2     = 4'd4,
      EV_TAP3     = 4'd5,
      EV_TUNER    = 4'd6,
      EV_SELECT   = 4'd7,
      EV_QUIT     = 4'd8
   } ev_bit_type;

   typedef logic [EV_N-1:0] ev_mask_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   function automatic age_type age_inc(input age_type a);
      return (a == {AGE_BITS{1'b1}}) ? a : a + 1'b1;
   endfunction

   function automatic logic age_ge(input age_type a, input cfg_type thr);
      return CMP_W'(a) >= CMP_W'(thr);
   endfunction

endpackage

// File: rtl/core/fgd_front.sv
// Front end: config registers, switch state tracking and per-tick event classification.
module fgd_front
   import fgd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [3:0]  req_switch_levels,
   input  logic        req_nav_level,
   input  logic        req_stop_request,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  cfg_type     csr_wdata,
   output logic        rec_valid,
   output ev_mask_type rec_mask
);

   cfg_type     combo_ff, tuner_ff, quit_ff;
   logic [3:0]  prev_ff, pend_ff, cons_ff;
   age_type     age_ff [4];
   logic        hold_ff, nav_prev_ff, nav_armed_ff, nav_holding_ff, nav_quitf_ff, halted_ff;
   age_type     nav_age_ff;

   logic [3:0]  prev_in, pend_in, cons_in, rise, fall;
   age_type     age_in [4];
   logic        hold_in, nav_armed_in, nav_holding_in, nav_quitf_in, halted_in;
   age_type     nav_age_in;
   logic [2:0]  lapse;
   ev_mask_type mask;
   logic        live;

   always_comb begin
      rise  = req_switch_levels & ~prev_ff;
      fall  = ~req_switch_levels & prev_ff;
      for (int i = 0; i < 4; i++) begin
         age_in[i] = rise[i] ? '0 : age_inc(age_ff[i]);
      end
      pend_in = pend_ff | rise;
      cons_in = cons_ff & ~rise;
      hold_in = hold_ff & ~rise[3];
      mask    = '0;
      lapse   = '0;

      // pair combos
      if ((&req_switch_levels[1:0]) && (&pend_in[1:0])) begin
         mask[EV_RIG_PREV] = 1'b1;
         pend_in[1:0]      = 2'b00;
         cons_in[1:0]      = 2'b11;
      end
      if ((&req_switch_levels[3:2]) && (&pend_in[3:2])) begin
         mask[EV_RIG_NEXT] = 1'b1;
         pend_in[3:2]      = 2'b00;
         cons_in[3:2]      = 2'b11;
      end

      // switches 0..2: tap on window lapse or early release
      for (int i = 0; i < 3; i++) begin
         lapse[i] = pend_in[i] && age_ge(age_in[i], combo_ff);
         if (pend_in[i] && (lapse[i] || fall[i])) begin
            mask[EV_TAP0 + i] = 1'b1;
         end
         if (lapse[i] || fall[i]) begin
            pend_in[i] = 1'b0;
         end
         if (fall[i]) begin
            cons_in[i] = 1'b0;
         end
      end

      // switch 3: tap on release, tuner hold on long press
      if (req_switch_levels[3]) begin
         if (age_ge(age_in[3], combo_ff)) begin
            pend_in[3] = 1'b0;
         end
         if (!hold_in && !cons_in[3] && age_ge(age_in[3], tuner_ff)) begin
            mask[EV_TUNER] = 1'b1;
            hold_in        = 1'b1;
         end
      end else if (prev_ff[3]) begin
         if (!hold_in && !cons_in[3]) begin
            mask[EV_TAP3] = 1'b1;
         end
         pend_in[3] = 1'b0;
         cons_in[3] = 1'b0;
      end
      prev_in = req_switch_levels;

      // nav switch
      nav_armed_in   = nav_armed_ff;
      nav_holding_in = nav_holding_ff;
      nav_quitf_in   = nav_quitf_ff;
      nav_age_in     = nav_age_ff;
      halted_in      = halted_ff;
      if (!req_nav_level) begin
         if (nav_prev_ff && nav_armed_ff && !nav_quitf_ff) begin
            mask[EV_SELECT] = 1'b1;
         end
         nav_armed_in   = 1'b1;
         nav_holding_in = 1'b0;
         nav_quitf_in   = 1'b0;
      end else begin
         if (!nav_prev_ff) begin
            nav_holding_in = 1'b1;
            nav_age_in     = '0;
         end else begin
            nav_age_in = age_inc(nav_age_ff);
         end
         if (nav_armed_ff && nav_holding_in && !nav_quitf_ff
             && age_ge(nav_age_in, quit_ff)) begin
            mask[EV_QUIT] = 1'b1;
            nav_quitf_in  = 1'b1;
            halted_in     = 1'b1;
         end
      end
   end

   assign live      = accept && !halted_ff;
   assign rec_valid = live && !req_stop_request && (mask != '0);
   assign rec_mask  = mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         combo_ff <= COMBO_RESET;
         tuner_ff <= TUNER_RESET;
         quit_ff  <= QUIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COMBO: combo_ff <= csr_wdata;
            CSR_TUNER: tuner_ff <= csr_wdata;
            CSR_QUIT:  quit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff        <= '0;
         pend_ff        <= '0;
         cons_ff        <= '0;
         hold_ff        <= 1'b0;
         nav_prev_ff    <= 1'b0;
         nav_armed_ff   <= 1'b0;
         nav_holding_ff <= 1'b0;
         nav_quitf_ff   <= 1'b0;
         nav_age_ff     <= '0;
         halted_ff      <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            age_ff[i] <= '0;
         end
      end else if (live) begin
         if (req_stop_request) begin
            halted_ff <= 1'b1;
         end else begin
            prev_ff        <= prev_in;
            pend_ff        <= pend_in;
            cons_ff        <= cons_in;
            hold_ff        <= hold_in;
            nav_prev_ff    <= req_nav_level;
            nav_armed_ff   <= nav_armed_in;
            nav_holding_ff <= nav_holding_in;
            nav_quitf_ff   <= nav_quitf_in;
            nav_age_ff     <= nav_age_in;
            halted_ff      <= halted_in;
            for (int i = 0; i < 4; i++) begin
               age_ff[i] <= age_in[i];
            end
         end
      end
   end

endmodule

// File: rtl/core/fgd_queue.sv
// Short queue of tick records between front and back.
`include "footswitch_gesture_decoder_defines.svh"
module fgd_queue
   import fgd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  ev_mask_type   push_data,
   input  logic          pop_valid,
   output ev_mask_type   head_data,
   output fifo_stat_type stat
);

   ev_mask_type      mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign do_push    = push_valid && !stat.full;
   assign do_pop     = pop_valid && !stat.empty;
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `FGD_ASSERT_NOW(a_no_push_when_full, clock, reset, push_valid, !stat.full)
   `FGD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(FIFO_DEPTH))
   `FGD_ASSERT_NEXT(a_push_not_empty, clock, reset, do_push, !stat.empty)

endmodule

// File: rtl/core/fgd_back.sv
// Back end: expands tick records into output-register events, one per cycle while pop keeps up.
`include "footswitch_gesture_decoder_defines.svh"
module fgd_back
   import fgd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ev_mask_type      q_head,
   input  fifo_stat_type    q_stat,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output logic [2:0]       rsp_event_kind,
   output logic [1:0]       rsp_switch_index,
   output logic signed [1:0] rsp_rig_direction,
   output logic             rsp_last_event
);

   ev_mask_type      mask_ff, mask_in, src, rest;
   ev_bit_type       sel;
   logic             out_valid_ff, out_valid_in, out_free, step;
   kind_type         kind_ff, kind_in;
   logic [1:0]       sw_ff, sw_in;
   logic signed [1:0] dir_ff, dir_in;
   logic             last_ff;

   always_comb begin
      src = (mask_ff != '0) ? mask_ff : (q_stat.empty ? '0 : q_head);
      out_free = !out_valid_ff || pop;
      step     = out_free && (src != '0);
      q_pop    = step && (mask_ff == '0);

      // lowest set bit goes first
      sel = EV_QUIT;
      for (int b = EV_N - 1; b >= 0; b--) begin
         if (src[b]) begin
            sel = ev_bit_type'(4'(b));
         end
      end
      rest      = src;
      rest[sel] = 1'b0;
      mask_in   = step ? rest : mask_ff;

      sw_in  = 2'd0;
      dir_in = RIG_NONE;
      unique case (sel)
         EV_RIG_PREV: begin kind_in = KIND_RIG; dir_in = RIG_PREV; end
         EV_RIG_NEXT: begin kind_in = KIND_RIG; dir_in = RIG_NEXT; end
         EV_TAP0:     begin kind_in = KIND_TAP; sw_in = 2'd0; end
         EV_TAP1:     begin kind_in = KIND_TAP; sw_in = 2'd1; end
         EV_TAP2:     begin kind_in = KIND_TAP; sw_in = 2'd2; end
         EV_TAP3:     begin kind_in = KIND_TAP; sw_in = 2'd3; end
         EV_TUNER:    begin kind_in = KIND_TUNER; sw_in = 2'd3; end
         EV_SELECT:   kind_in = KIND_SELECT;
         EV_QUIT:     kind_in = KIND_QUIT;
         default:     kind_in = KIND_TAP;
      endcase

      out_valid_in = step ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         kind_ff <= kind_in;
         sw_ff   <= sw_in;
         dir_ff  <= dir_in;
         last_ff <= (rest == '0);
      end
   end

   assign empty             = !out_valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_switch_index  = sw_ff;
   assign rsp_rig_direction = dir_ff;
   assign rsp_last_event    = last_ff;

   `FGD_ASSERT_NEXT(a_last_drains, clock, reset, step && (rest == '0), mask_ff == '0)
   `FGD_ASSERT_NOW(a_quit_is_last, clock, reset, out_valid_ff && (kind_ff == KIND_QUIT), last_ff)
   `FGD_ASSERT_NOW(a_pop_only_from_queue, clock, reset, q_pop, !q_stat.empty)

endmodule

// File: rtl/core/footswitch_gesture_decoder.sv
// Top level of the footswitch gesture decoder.
// Usage:
//  - Input side is a queue: drive req_* with one tick sample and raise push; the transfer
//    happens at an edge with push high and full low. One tick per cycle is taken while not full.
//  - Result side is a queue: while empty is low the oldest event sits on rsp_*; raise pop
//    to take it. rsp_last_event marks the final event caused by one tick.
//  - Config: csr_write_enable with csr_index 0 (combo window), 1 (tuner hold),
//    2 (quit hold) and csr_wdata writes in that cycle; index 3 is ignored. Write while idle.
// Flow:
//  - A tick is classified in the cycle of its transfer and its record enters the queue
//    at that edge; the back end then loads its first event into the output register, which
//    drives rsp_*. Events leave that single back-end event register one at a time, a
//    tick yields up to 5 events, and the next record is taken from the queue only once
//    the last event of the record before has been loaded.
//  - A tick with no events produces no result.
// Stall:
//  - Ticks with events wait as records in a 4-entry queue; when it fills, full rises
//    and holds off further ticks until the receiver pops again.
// Reset (synchronous, active high) restores register defaults, clears all switch
// state, the queue and the result register. After quit or a stop request, ticks are
// still taken but produce nothing until reset.
module footswitch_gesture_decoder
   import fgd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [3:0]        req_switch_levels,
   input  logic              req_nav_level,
   input  logic              req_stop_request,
   output logic              empty,
   input  logic              pop,
   output logic [2:0]        rsp_event_kind,
   output logic [1:0]        rsp_switch_index,
   output logic signed [1:0] rsp_rig_direction,
   output logic              rsp_last_event,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [11:0]       csr_wdata
);

   logic          accept, rec_valid, q_pop;
   ev_mask_type   rec_mask, q_head;
   fifo_stat_type q_stat;

   // input transfer only when a record slot is free
   assign full   = q_stat.full;
   assign accept = push && !q_stat.full;

   fgd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_switch_levels (req_switch_levels),
      .req_nav_level     (req_nav_level),
      .req_stop_request  (req_stop_request),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rec_valid         (rec_valid),
      .rec_mask          (rec_mask)
   );

   // one entry per tick that has events; bit order is the delivery order
   fgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (rec_valid),
      .push_data  (rec_mask),
      .pop_valid  (q_pop),
      .head_data  (q_head),
      .stat       (q_stat)
   );

   fgd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (q_head),
      .q_stat            (q_stat),
      .q_pop             (q_pop),
      .pop               (pop),
      .empty             (empty),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_switch_index  (rsp_switch_index),
      .rsp_rig_direction (rsp_rig_direction),
      .rsp_last_event    (rsp_last_event)
   );

endmodule
